// ----- hw/rtl/pgd_pkg.sv -----
// shared widths, caps and allele codes for the pairwise genotype distance block
package pgd_pkg;

    // field widths
    localparam int SITE_W   = 21;
    localparam int BASE_W   = 22;
    localparam int ALLELE_W = 8;
    localparam int NUM_BASES = 4;

    // packed stream widths
    localparam int IN_W      = 4 * ALLELE_W;
    localparam int OUT_BITS  = 2 * BASE_W + 6 * SITE_W + NUM_BASES * BASE_W - BASE_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    // saturation limits
    localparam longint unsigned MAX_SITES  = 64'd1048576;
    localparam longint unsigned SITE_LIMIT = (64'd1 << SITE_W) - 64'd1;
    localparam longint unsigned BASE_LIMIT = (64'd1 << BASE_W) - 64'd1;
    localparam longint unsigned SITE_CAP   = (MAX_SITES < SITE_LIMIT) ? MAX_SITES : SITE_LIMIT;
    localparam longint unsigned BASE_CAP   = (MAX_SITES > BASE_LIMIT) ? BASE_LIMIT :
                                             ((2 * MAX_SITES < BASE_LIMIT) ? 2 * MAX_SITES
                                                                           : BASE_LIMIT);

    localparam logic [SITE_W-1:0] SITE_CAP_V  = SITE_W'(SITE_CAP);
    localparam logic [BASE_W-1:0] BASE_CAP_V  = BASE_W'(BASE_CAP);
    localparam logic [BASE_W-1:0] TOTAL_MAX_V = BASE_W'(BASE_LIMIT);

    // missing-call codes
    localparam logic [ALLELE_W-1:0] MISS_N    = 8'h4E;
    localparam logic [ALLELE_W-1:0] MISS_ZERO = 8'h30;

    // base codes in counter order A, C, G, T
    localparam logic [ALLELE_W-1:0] BASE_CODES [NUM_BASES] = '{8'h41, 8'h43, 8'h47, 8'h54};

endpackage

// ----- hw/rtl/pairwise_genotype_distance.sv -----
// pairwise genotype distance accumulator: site classification and saturating counts
//
// Usage:
// - input channel s_*: one item per SNP site; s_tdata carries the four allele
//   bytes of individuals A and B, s_tlast marks the final site of the pair
// - result channel m_*: one item per pair, issued for the site that has s_tlast
//   set; it carries the distance in half units and all site and allele counts
// - an accepted item is held in an input register and counted from there;
//   the result for a last site is registered when that site leaves the input register
// - throughput is one item per clock unless a last site waits on a pending result:
//   the only work per item is a few byte compares and a saturating increment of each counter
// - counters saturate at their caps; total distance saturates at 2^22-1
// - after the last site all counters restart at zero for the next pair
// - reset (aresetn low, synchronous) clears the counters, the valid and last flags
//   of the input register and the result valid
// - when the receiver stalls, a pending result is held in the result register;
//   ordinary sites keep flowing, and a further last site waits in the input
//   register until the pending result is taken
module pairwise_genotype_distance (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // allele_a_first, allele_a_second, allele_b_first, allele_b_second
    input  logic [pgd_pkg::IN_W-1:0]    s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // total_half_units, half_score_sites, full_score_sites, zero_score_sites,
    // valid_sites, het_sites_a, called_sites_a, count_adenine, count_cytosine,
    // count_guanine, count_thymine, zero padding
    output logic [pgd_pkg::OUT_W-1:0]   m_tdata
);

    localparam int SW = pgd_pkg::SITE_W;
    localparam int BW = pgd_pkg::BASE_W;
    localparam int AW = pgd_pkg::ALLELE_W;
    localparam int NB = pgd_pkg::NUM_BASES;

    // input register
    logic                       in_valid_reg, in_valid_next;
    logic                       in_last_reg,  in_last_next;
    logic [pgd_pkg::IN_W-1:0]   in_data_reg,  in_data_next;

    // running counters
    logic [SW-1:0] half_reg,   half_next;
    logic [SW-1:0] full_reg,   full_next;
    logic [SW-1:0] zero_reg,   zero_next;
    logic [SW-1:0] valid_reg,  valid_next;
    logic [SW-1:0] het_reg,    het_next;
    logic [SW-1:0] called_reg, called_next;
    logic [BW-1:0] base_reg  [NB];
    logic [BW-1:0] base_next [NB];

    // result register
    logic          out_valid_reg, out_valid_next;
    logic [BW-1:0] o_total_reg,  o_total_next;
    logic [SW-1:0] o_half_reg,   o_half_next;
    logic [SW-1:0] o_full_reg,   o_full_next;
    logic [SW-1:0] o_zero_reg,   o_zero_next;
    logic [SW-1:0] o_valid_reg,  o_valid_next;
    logic [SW-1:0] o_het_reg,    o_het_next;
    logic [SW-1:0] o_called_reg, o_called_next;
    logic [BW-1:0] o_base_reg  [NB];
    logic [BW-1:0] o_base_next [NB];

    // site classification
    logic [AW-1:0] a1, a2, b1, b2;
    logic          a_hom, b_hom, a1_miss, a2_miss, b1_miss;
    logic          is_half, is_full, is_zero, is_scored, a_called, a_het;
    logic [1:0]    base_inc [NB];

    // updated counter values for the item in the input register
    logic [SW-1:0] half_upd, full_upd, zero_upd, valid_upd, het_upd, called_upd;
    logic [BW-1:0] base_upd [NB];
    logic [BW:0]   total_sum;

    logic advance, do_step, out_load;

    function automatic logic [SW-1:0] site_bump(input logic [SW-1:0] c, input logic en);
        logic [SW-1:0] r;
        r = c;
        if (en && (c < pgd_pkg::SITE_CAP_V)) begin
            r = c + SW'(1);
        end
        return r;
    endfunction

    function automatic logic [BW-1:0] base_bump(input logic [BW-1:0] c, input logic [1:0] inc);
        logic [BW:0] s;
        s = {1'b0, c} + (BW+1)'(inc);
        if (s > {1'b0, pgd_pkg::BASE_CAP_V}) begin
            return pgd_pkg::BASE_CAP_V;
        end
        return s[BW-1:0];
    endfunction

    // handshake: the input register moves on unless a last site meets a full result
    assign advance  = !in_last_reg || !out_valid_reg || m_tready;
    assign do_step  = in_valid_reg && advance;
    assign out_load = do_step && in_last_reg;
    assign s_tready = !in_valid_reg || advance;

    // classify the registered site
    always_comb begin
        a1 = in_data_reg[0*AW +: AW];
        a2 = in_data_reg[1*AW +: AW];
        b1 = in_data_reg[2*AW +: AW];
        b2 = in_data_reg[3*AW +: AW];
        a_hom   = (a1 == a2);
        b_hom   = (b1 == b2);
        a1_miss = (a1 == pgd_pkg::MISS_N) || (a1 == pgd_pkg::MISS_ZERO);
        a2_miss = (a2 == pgd_pkg::MISS_N) || (a2 == pgd_pkg::MISS_ZERO);
        b1_miss = (b1 == pgd_pkg::MISS_N) || (b1 == pgd_pkg::MISS_ZERO);
        is_half   = !a_hom || !b_hom;
        is_full   = !is_half && (a1 != b1) && !a1_miss && !b1_miss;
        is_zero   = !is_half && (a1 == b1);
        is_scored = is_half || is_full || is_zero;
        a_called  = !a1_miss && !a2_miss;
        a_het     = a_called && !a_hom;
        for (int k = 0; k < NB; k++) begin
            base_inc[k] = {1'b0, (a1 == pgd_pkg::BASE_CODES[k])}
                        + {1'b0, (a2 == pgd_pkg::BASE_CODES[k])};
        end
    end

    // saturating counter updates
    always_comb begin
        half_upd   = site_bump(half_reg,   is_half);
        full_upd   = site_bump(full_reg,   is_full);
        zero_upd   = site_bump(zero_reg,   is_zero);
        valid_upd  = site_bump(valid_reg,  is_scored);
        het_upd    = site_bump(het_reg,    a_het);
        called_upd = site_bump(called_reg, a_called);
        for (int k = 0; k < NB; k++) begin
            base_upd[k] = base_bump(base_reg[k], base_inc[k]);
        end
        total_sum = (BW+1)'(half_upd) + ((BW+1)'(full_upd) << 1);
    end

    // next state of input register, counters and result register
    always_comb begin
        in_valid_next = in_valid_reg;
        in_last_next  = in_last_reg;
        in_data_next  = in_data_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            if (s_tvalid) begin
                in_last_next = s_tlast;
                in_data_next = s_tdata;
            end
        end

        half_next   = half_reg;
        full_next   = full_reg;
        zero_next   = zero_reg;
        valid_next  = valid_reg;
        het_next    = het_reg;
        called_next = called_reg;
        for (int k = 0; k < NB; k++) begin
            base_next[k] = base_reg[k];
        end
        if (do_step) begin
            if (in_last_reg) begin
                half_next   = '0;
                full_next   = '0;
                zero_next   = '0;
                valid_next  = '0;
                het_next    = '0;
                called_next = '0;
                for (int k = 0; k < NB; k++) begin
                    base_next[k] = '0;
                end
            end else begin
                half_next   = half_upd;
                full_next   = full_upd;
                zero_next   = zero_upd;
                valid_next  = valid_upd;
                het_next    = het_upd;
                called_next = called_upd;
                for (int k = 0; k < NB; k++) begin
                    base_next[k] = base_upd[k];
                end
            end
        end

        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end

        o_total_next  = o_total_reg;
        o_half_next   = o_half_reg;
        o_full_next   = o_full_reg;
        o_zero_next   = o_zero_reg;
        o_valid_next  = o_valid_reg;
        o_het_next    = o_het_reg;
        o_called_next = o_called_reg;
        for (int k = 0; k < NB; k++) begin
            o_base_next[k] = o_base_reg[k];
        end
        if (out_load) begin
            o_total_next  = (total_sum > {1'b0, pgd_pkg::TOTAL_MAX_V}) ? pgd_pkg::TOTAL_MAX_V
                                                                       : total_sum[BW-1:0];
            o_half_next   = half_upd;
            o_full_next   = full_upd;
            o_zero_next   = zero_upd;
            o_valid_next  = valid_upd;
            o_het_next    = het_upd;
            o_called_next = called_upd;
            for (int k = 0; k < NB; k++) begin
                o_base_next[k] = base_upd[k];
            end
        end
    end

    // control state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            in_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            half_reg      <= '0;
            full_reg      <= '0;
            zero_reg      <= '0;
            valid_reg     <= '0;
            het_reg       <= '0;
            called_reg    <= '0;
            for (int k = 0; k < NB; k++) begin
                base_reg[k] <= '0;
            end
        end else begin
            in_valid_reg  <= in_valid_next;
            in_last_reg   <= in_last_next;
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
            full_reg      <= full_next;
            zero_reg      <= zero_next;
            valid_reg     <= valid_next;
            het_reg       <= het_next;
            called_reg    <= called_next;
            for (int k = 0; k < NB; k++) begin
                base_reg[k] <= base_next[k];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_data_reg  <= in_data_next;
        o_total_reg  <= o_total_next;
        o_half_reg   <= o_half_next;
        o_full_reg   <= o_full_next;
        o_zero_reg   <= o_zero_next;
        o_valid_reg  <= o_valid_next;
        o_het_reg    <= o_het_next;
        o_called_reg <= o_called_next;
        for (int k = 0; k < NB; k++) begin
            o_base_reg[k] <= o_base_next[k];
        end
    end

    // result packing, first field in the low bits
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pgd_pkg::OUT_W'({o_base_reg[3], o_base_reg[2], o_base_reg[1], o_base_reg[0],
                                       o_called_reg, o_het_reg, o_valid_reg, o_zero_reg,
                                       o_full_reg, o_half_reg, o_total_reg});

endmodule

// ----- hw/rtl/pgd_checker.sv -----
// port-level checks for the pairwise genotype distance block, with bind
module pgd_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [pgd_pkg::OUT_W-1:0]  m_tdata
);

    // result fields
    logic [pgd_pkg::BASE_W-1:0] c_total;
    logic [pgd_pkg::SITE_W-1:0] c_half, c_full, c_zero, c_valid, c_het, c_called;
    logic [pgd_pkg::BASE_W:0]   c_sum;

    assign c_total  = m_tdata[21:0];
    assign c_half   = m_tdata[42:22];
    assign c_full   = m_tdata[63:43];
    assign c_zero   = m_tdata[84:64];
    assign c_valid  = m_tdata[105:85];
    assign c_het    = m_tdata[126:106];
    assign c_called = m_tdata[147:127];
    assign c_sum    = (pgd_pkg::BASE_W+1)'(c_half) + ((pgd_pkg::BASE_W+1)'(c_full) << 1);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // distance equals half plus twice full, saturated
    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((c_sum > (pgd_pkg::BASE_W+1)'(pgd_pkg::TOTAL_MAX_V))
                      ? (c_total == pgd_pkg::TOTAL_MAX_V)
                      : (c_total == c_sum[pgd_pkg::BASE_W-1:0])))
        else $error("total distance does not match its parts");

    // every scored site is also counted as valid
    a_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (c_valid >= c_half) && (c_valid >= c_full) && (c_valid >= c_zero))
        else $error("valid count below a score count");

    // heterozygous sites of A are a subset of its called sites
    a_het: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> c_het <= c_called)
        else $error("heterozygous count exceeds called count");

endmodule

bind pairwise_genotype_distance pgd_checker u_pgd_checker (.*);

// ----- dv/pgd_distance_checker.sv -----
// checker for the pairwise genotype distance block: counts each accepted site and compares results
module pgd_distance_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    // allele_a_first, allele_a_second, allele_b_first, allele_b_second
    input  logic [pgd_pkg::IN_W-1:0]  s_tdata,
    input  logic                      s_tlast,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    // total_half_units, half_score_sites, full_score_sites, zero_score_sites,
    // valid_sites, het_sites_a, called_sites_a, count_adenine, count_cytosine,
    // count_guanine, count_thymine, zero padding
    input  logic [pgd_pkg::OUT_W-1:0] m_tdata,
    output int                        fail_count,
    output int                        results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // saturation points of the site, base and distance counts
    localparam int unsigned SITE_SAT  = 1048576;
    localparam int unsigned BASE_SAT  = 2097152;
    localparam int unsigned TOTAL_SAT = 4194303;

    // one pair result, total distance in the lowest bits
    typedef struct packed {
        logic [21:0] n_thy;
        logic [21:0] n_gua;
        logic [21:0] n_cyt;
        logic [21:0] n_ade;
        logic [20:0] called_a;
        logic [20:0] het_a;
        logic [20:0] valid_sites;
        logic [20:0] zero_sites;
        logic [20:0] full_sites;
        logic [20:0] half_sites;
        logic [21:0] total_half;
    } pair_counts_t;

    localparam int COUNTS_W = $bits(pair_counts_t);

    pair_counts_t pair_results_q [$];

    // running counts of the current pair
    int unsigned half_n;
    int unsigned full_n;
    int unsigned zero_n;
    int unsigned valid_n;
    int unsigned het_n;
    int unsigned called_n;
    int unsigned base_n [pgd_pkg::NUM_BASES];

    int mismatches  = 0;
    int outstanding = 0;

    assign fail_count      = mismatches;
    assign results_pending = outstanding;

    function automatic int unsigned sat_inc(input int unsigned v, input int unsigned cap);
        return (v < cap) ? v + 1 : v;
    endfunction

    function automatic bit no_call(input logic [7:0] x);
        return (x == pgd_pkg::MISS_N) || (x == pgd_pkg::MISS_ZERO);
    endfunction

    task automatic clear_counts();
        half_n   = 0;
        full_n   = 0;
        zero_n   = 0;
        valid_n  = 0;
        het_n    = 0;
        called_n = 0;
        for (int k = 0; k < pgd_pkg::NUM_BASES; k++) begin
            base_n[k] = 0;
        end
    endtask

    // score one site, and on the last site of a pair queue the pair result
    task automatic count_site(input logic [7:0] a1, input logic [7:0] a2,
                              input logic [7:0] b1, input logic [7:0] b2,
                              input logic last);
        pair_counts_t res;
        int unsigned  total;
        if (a1 != a2 || b1 != b2) begin
            half_n  = sat_inc(half_n, SITE_SAT);
            valid_n = sat_inc(valid_n, SITE_SAT);
        end else if (a1 != b1) begin
            // opposite homozygotes only score when neither is a no-call
            if (!no_call(a1) && !no_call(b1)) begin
                full_n  = sat_inc(full_n, SITE_SAT);
                valid_n = sat_inc(valid_n, SITE_SAT);
            end
        end else begin
            zero_n  = sat_inc(zero_n, SITE_SAT);
            valid_n = sat_inc(valid_n, SITE_SAT);
        end

        // statistics of individual a
        if (!no_call(a1) && !no_call(a2)) begin
            if (a1 != a2) begin
                het_n = sat_inc(het_n, SITE_SAT);
            end
            called_n = sat_inc(called_n, SITE_SAT);
        end
        for (int k = 0; k < pgd_pkg::NUM_BASES; k++) begin
            if (a1 == pgd_pkg::BASE_CODES[k]) begin
                base_n[k] = sat_inc(base_n[k], BASE_SAT);
            end
            if (a2 == pgd_pkg::BASE_CODES[k]) begin
                base_n[k] = sat_inc(base_n[k], BASE_SAT);
            end
        end

        if (last) begin
            total = half_n + 2 * full_n;
            if (total > TOTAL_SAT) begin
                total = TOTAL_SAT;
            end
            res.total_half  = 22'(total);
            res.half_sites  = 21'(half_n);
            res.full_sites  = 21'(full_n);
            res.zero_sites  = 21'(zero_n);
            res.valid_sites = 21'(valid_n);
            res.het_a       = 21'(het_n);
            res.called_a    = 21'(called_n);
            res.n_ade       = 22'(base_n[0]);
            res.n_cyt       = 22'(base_n[1]);
            res.n_gua       = 22'(base_n[2]);
            res.n_thy       = 22'(base_n[3]);
            pair_results_q = {pair_results_q, res};
            clear_counts();
        end
    endtask

    task automatic check_field(input string name, input logic [21:0] want,
                               input logic [21:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // compare the result item first, then count the accepted site
    always @(posedge aclk) begin
        pair_counts_t got;
        pair_counts_t want;
        if (!aresetn) begin
            clear_counts();
            pair_results_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pair_results_q.size() == 0) begin
                    $error("result item with no pair pending");
                    mismatches++;
                end else begin
                    got  = pair_counts_t'(m_tdata[COUNTS_W-1:0]);
                    want = pair_results_q.pop_front();
                    check_field("total_half_units", want.total_half, got.total_half);
                    check_field("half_score_sites", want.half_sites, got.half_sites);
                    check_field("full_score_sites", want.full_sites, got.full_sites);
                    check_field("zero_score_sites", want.zero_sites, got.zero_sites);
                    check_field("valid_sites", want.valid_sites, got.valid_sites);
                    check_field("het_sites_a", want.het_a, got.het_a);
                    check_field("called_sites_a", want.called_a, got.called_a);
                    check_field("count_adenine", want.n_ade, got.n_ade);
                    check_field("count_cytosine", want.n_cyt, got.n_cyt);
                    check_field("count_guanine", want.n_gua, got.n_gua);
                    check_field("count_thymine", want.n_thy, got.n_thy);
                end
            end
            if (s_tvalid && s_tready) begin
                count_site(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tdata[31:24],
                           s_tlast);
            end
        end
        outstanding = pair_results_q.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// top of the pairwise genotype distance testbench: clock, reset, site stimulus and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 1450;
    localparam int unsigned PRESS_ITEMS  = 30;
    localparam int unsigned PRESS_HOLD   = 150;
    localparam int unsigned TAIL_CYCLES  = 10;

    localparam logic [7:0] ADE      = pgd_pkg::BASE_CODES[0];
    localparam logic [7:0] CYT      = pgd_pkg::BASE_CODES[1];
    localparam logic [7:0] GUA      = pgd_pkg::BASE_CODES[2];
    localparam logic [7:0] THY      = pgd_pkg::BASE_CODES[3];
    localparam logic [7:0] NOC_N    = pgd_pkg::MISS_N;
    localparam logic [7:0] NOC_Z    = pgd_pkg::MISS_ZERO;
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [7:0] BYTE_LO  = 8'h00;
    localparam logic [7:0] BYTE_HI  = 8'hFF;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    // allele_a_first, allele_a_second, allele_b_first, allele_b_second
    logic [pgd_pkg::IN_W-1:0]  s_tdata;
    logic                      s_tlast;
    logic                      m_tvalid;
    logic                      m_tready;
    // total_half_units, half_score_sites, full_score_sites, zero_score_sites,
    // valid_sites, het_sites_a, called_sites_a, count_adenine, count_cytosine,
    // count_guanine, count_thymine, zero padding
    logic [pgd_pkg::OUT_W-1:0] m_tdata;

    int fail_count;
    int results_pending;

    // shared pacing controls
    int unsigned hold_cycles = 0;
    bit          rx_calm     = 1'b0;
    bit          tx_burst    = 1'b0;

    pairwise_genotype_distance u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pgd_distance_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #60_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // sender gap: mostly none, some short, a few long
    function automatic int unsigned tx_gap();
        int unsigned r;
        if (tx_burst) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // receiver stall after each ready cycle
    function automatic int unsigned rx_stall();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // allele byte: mostly bases and no-calls, some lowercase and raw bytes
    function automatic logic [7:0] pick_allele();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                return pgd_pkg::BASE_CODES[$urandom_range(0, 3)];
            end
            4: begin
                return NOC_N;
            end
            5: begin
                return NOC_Z;
            end
            6: begin
                return pgd_pkg::BASE_CODES[$urandom_range(0, 3)] | CASE_BIT;
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    // one site of a chosen genotype shape, or plain noise
    task automatic random_site(output logic [7:0] a1, output logic [7:0] a2,
                               output logic [7:0] b1, output logic [7:0] b2);
        logic [7:0] x;
        logic [7:0] y;
        x = pick_allele();
        y = pick_allele();
        case ($urandom_range(0, 9))
            0, 1: begin
                a1 = x; a2 = x; b1 = x; b2 = x;
            end
            2, 3, 4: begin
                a1 = x; a2 = x; b1 = y; b2 = y;
            end
            5, 6: begin
                a1 = x; a2 = y;
                b1 = pick_allele(); b2 = b1;
            end
            7: begin
                a1 = pick_allele(); a2 = a1;
                b1 = x; b2 = y;
            end
            default: begin
                a1 = 8'($urandom_range(0, 255));
                a2 = 8'($urandom_range(0, 255));
                b1 = 8'($urandom_range(0, 255));
                b2 = 8'($urandom_range(0, 255));
            end
        endcase
    endtask

    // offer one site item and wait for its handshake; called and returns at a falling edge
    task automatic send_site(input logic [7:0] a1, input logic [7:0] a2,
                             input logic [7:0] b1, input logic [7:0] b2,
                             input logic last, input int unsigned gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b2, b1, a2, a1};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // sender pause until every pair result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (results_pending != 0);
    endtask

    // receiver: long hold-offs on request, random stalls otherwise
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready   <= 1'b1;
                stall_left = rx_calm ? 0 : rx_stall();
            end
        end
    end

    // stimulus and verdict
    initial begin
        logic [7:0]  a1;
        logic [7:0]  a2;
        logic [7:0]  b1;
        logic [7:0]  b2;
        int unsigned sent;
        int unsigned len;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed pair covering every site class
        send_site(ADE, ADE, CYT, CYT, 1'b0, tx_gap());  // opposite homozygotes
        send_site(ADE, CYT, ADE, ADE, 1'b0, tx_gap());  // a heterozygous
        send_site(GUA, GUA, GUA, THY, 1'b0, tx_gap());  // b heterozygous
        send_site(THY, THY, THY, THY, 1'b0, tx_gap());  // identical homozygotes
        send_site(NOC_N, NOC_N, ADE, ADE, 1'b0, tx_gap());  // no-call vs homozygote
        send_site(NOC_Z, NOC_Z, GUA, GUA, 1'b0, tx_gap());
        send_site(NOC_N, NOC_N, NOC_N, NOC_N, 1'b0, tx_gap());  // no-call vs same
        send_site(NOC_N, NOC_Z, CYT, CYT, 1'b0, tx_gap());  // heterozygote of no-calls
        send_site(ADE, NOC_N, ADE, ADE, 1'b0, tx_gap());
        send_site(ADE | CASE_BIT, ADE | CASE_BIT, ADE, ADE, 1'b0, tx_gap());  // lowercase
        send_site(BYTE_HI, BYTE_HI, NOC_Z, NOC_Z, 1'b0, tx_gap());
        send_site(NOC_Z, NOC_Z, NOC_Z, NOC_Z, 1'b1, tx_gap());
        // single-site pairs, some with extreme bytes
        send_site(ADE, ADE, CYT, CYT, 1'b1, tx_gap());
        send_site(BYTE_LO, BYTE_HI, BYTE_HI, BYTE_LO, 1'b1, tx_gap());
        send_site(BYTE_HI, BYTE_HI, BYTE_HI, BYTE_HI, 1'b1, tx_gap());
        send_site(BYTE_LO, BYTE_LO, BYTE_LO, BYTE_LO, 1'b1, tx_gap());
        send_site(ADE, THY, GUA, CYT, 1'b1, tx_gap());
        wait_drained();

        // back-pressure: receiver held off while short pairs keep coming
        rx_calm     = 1'b0;
        hold_cycles = PRESS_HOLD;
        for (int unsigned i = 0; i < PRESS_ITEMS; i++) begin
            random_site(a1, a2, b1, b2);
            send_site(a1, a2, b1, b2, (i % 3) == 2, 0);
        end
        wait_drained();

        // random pairs of random length
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len      = ($urandom_range(0, 6) == 0) ? 1 : $urandom_range(2, 40);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_calm  = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 14) == 0) begin
                hold_cycles = $urandom_range(30, 80);
            end
            for (int unsigned k = 0; k < len; k++) begin
                random_site(a1, a2, b1, b2);
                send_site(a1, a2, b1, b2, k == len - 1, tx_gap());
            end
            sent += len;
            if ($urandom_range(0, 9) == 0) begin
                wait_drained();
            end
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pgd_pkg.sv
hw/rtl/pairwise_genotype_distance.sv
hw/rtl/pgd_checker.sv
dv/pgd_distance_checker.sv
dv/tb_top.sv
